>>> rtl/core/dgmt_pkg.sv
// shared constants, types and helper functions of the depth grid mesh triangulator
package dgmt_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int FLOAT_W = 32;
   localparam int IDX_W   = 18;
   localparam int TOT_W   = 19;
   localparam int FACE_W  = 20;
   localparam int KIND_W  = 2;
   localparam int CFG_W   = 10;
   localparam int CSR_IDX_W = 8;

   localparam int WIDTH_RESET  = 512;
   localparam int HEIGHT_RESET = 424;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   // result kinds
   localparam logic [KIND_W-1:0] KIND_VERTEX   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TOTALS   = 2'd2;

   // result queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // line buffer entry: valid mark above the vertex index
   localparam int LINE_W = IDX_W + 1;

   typedef struct packed {
      logic vertex;
      logic lower;
      logic upper;
      logic totals;
   } flags_type;

   typedef struct packed {
      flags_type              flags;
      logic [FLOAT_W-1:0]     x;
      logic [FLOAT_W-1:0]     y;
      logic [FLOAT_W-1:0]     z;
      logic [IDX_W-1:0]       above_left;
      logic [IDX_W-1:0]       left;
      logic [IDX_W-1:0]       cur;
      logic [IDX_W-1:0]       top_right;
      logic [TOT_W-1:0]       vertex_total;
      logic [TOT_W-1:0]       face_total;
   } result_rec_type;

   function automatic logic [COL_W-1:0] width_last(input logic [CFG_W-1:0] v);
      int n;
      n = int'(v);
      if (n < 2) n = 2;
      if (n > MAX_WIDTH) n = MAX_WIDTH;
      return COL_W'(n - 1);
   endfunction

   function automatic logic [ROW_W-1:0] height_last(input logic [CFG_W-1:0] v);
      int n;
      n = int'(v);
      if (n < 2) n = 2;
      if (n > MAX_HEIGHT) n = MAX_HEIGHT;
      return ROW_W'(n - 1);
   endfunction

   function automatic logic [FLOAT_W-1:0] clear_nan(input logic [FLOAT_W-1:0] b);
      if (b[30:23] == 8'hFF && b[22:0] != 23'd0) return '0;
      return b;
   endfunction

endpackage

>>> rtl/core/dgmt_if.sv
// pixel request, result and register write channels
interface dgmt_req_if;
   import dgmt_pkg::*;
   logic               valid;
   logic               ready;
   logic               skipped;
   logic [FLOAT_W-1:0] x_in;
   logic [FLOAT_W-1:0] y_in;
   logic [FLOAT_W-1:0] z_in;
   modport source (output valid, skipped, x_in, y_in, z_in, input ready);
   modport sink   (input valid, skipped, x_in, y_in, z_in, output ready);
endinterface

interface dgmt_rsp_if;
   import dgmt_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [FLOAT_W-1:0] x_out;
   logic [FLOAT_W-1:0] y_out;
   logic [FLOAT_W-1:0] z_out;
   logic [IDX_W-1:0]   corner_a;
   logic [IDX_W-1:0]   corner_b;
   logic [IDX_W-1:0]   corner_c;
   logic [TOT_W-1:0]   vertex_total;
   logic [TOT_W-1:0]   face_total;
   logic               last;
   modport source (output valid, kind, x_out, y_out, z_out, corner_a, corner_b, corner_c,
                   vertex_total, face_total, last, input ready);
   modport sink   (input valid, kind, x_out, y_out, z_out, corner_a, corner_b, corner_c,
                   vertex_total, face_total, last, output ready);
endinterface

interface dgmt_csr_if;
   import dgmt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/dgmt_ram.sv
// generic single write port, single read port ram with registered read
module dgmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/dgmt_out_queue.sv
// result record queue that unpacks each record into vertex, triangle and totals results
module dgmt_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  dgmt_pkg::result_rec_type      push_rec,
   output logic [dgmt_pkg::Q_CNT_W-1:0]  fill,
   dgmt_rsp_if.source                    rsp_chan
);
   import dgmt_pkg::*;

   result_rec_type       rec_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   head_ff;
   logic [Q_PTR_W-1:0]   tail_ff;
   logic [Q_CNT_W-1:0]   fill_ff;
   logic [Q_PTR_W-1:0]   head_in;
   logic [Q_PTR_W-1:0]   tail_in;
   logic [Q_CNT_W-1:0]   fill_in;

   result_rec_type       head_rec;
   logic [3:0]           flag_bits;
   logic [3:0]           sel_bits;
   logic [3:0]           rem_bits;
   logic                 pop_step;
   logic                 rec_done;

   function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
      if (p == Q_PTR_W'(Q_DEPTH - 1)) return '0;
      return p + Q_PTR_W'(1);
   endfunction

   assign head_rec  = rec_ff[head_ff];
   assign flag_bits = head_rec.flags;

   // results of one record leave in order vertex, lower, upper, totals
   always_comb begin
      rsp_chan.kind         = KIND_VERTEX;
      rsp_chan.x_out        = '0;
      rsp_chan.y_out        = '0;
      rsp_chan.z_out        = '0;
      rsp_chan.corner_a     = '0;
      rsp_chan.corner_b     = '0;
      rsp_chan.corner_c     = '0;
      rsp_chan.vertex_total = '0;
      rsp_chan.face_total   = '0;
      sel_bits              = 4'b0001;
      if (head_rec.flags.vertex) begin
         sel_bits       = 4'b1000;
         rsp_chan.x_out = head_rec.x;
         rsp_chan.y_out = head_rec.y;
         rsp_chan.z_out = head_rec.z;
      end else if (head_rec.flags.lower) begin
         sel_bits          = 4'b0100;
         rsp_chan.kind     = KIND_TRIANGLE;
         rsp_chan.corner_a = head_rec.above_left;
         rsp_chan.corner_b = head_rec.left;
         rsp_chan.corner_c = head_rec.cur;
      end else if (head_rec.flags.upper) begin
         sel_bits          = 4'b0010;
         rsp_chan.kind     = KIND_TRIANGLE;
         rsp_chan.corner_a = head_rec.above_left;
         rsp_chan.corner_b = head_rec.cur;
         rsp_chan.corner_c = head_rec.top_right;
      end else begin
         rsp_chan.kind         = KIND_TOTALS;
         rsp_chan.vertex_total = head_rec.vertex_total;
         rsp_chan.face_total   = head_rec.face_total;
      end
   end

   assign rem_bits      = flag_bits & ~sel_bits;
   assign rec_done      = (rem_bits == 4'b0000);
   assign rsp_chan.last = rec_done;
   assign rsp_chan.valid = (fill_ff != '0);
   assign pop_step      = rsp_chan.valid && rsp_chan.ready;
   assign fill          = fill_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         tail_in = ptr_next(tail_ff);
      end
      if (pop_step && rec_done) begin
         head_in = ptr_next(head_ff);
      end
      if (push && !(pop_step && rec_done)) begin
         fill_in = fill_ff + Q_CNT_W'(1);
      end else if (!push && pop_step && rec_done) begin
         fill_in = fill_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // tail never meets a non-empty head, so both writes may land in one cycle
   always_ff @(posedge clock) begin
      if (push) rec_ff[tail_ff] <= push_rec;
      if (pop_step && !rec_done) rec_ff[head_ff].flags <= flags_type'(rem_bits);
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff < Q_CNT_W'(Q_DEPTH)))
      else $error("result queue pushed while full");

   a_head_has_work : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (flag_bits != 4'b0000))
      else $error("queued record without pending results");
endmodule

>>> rtl/core/depth_grid_mesh_triangulator.sv
// top level of the depth grid mesh triangulator
//
// Pixels enter on req_chan in raster order, one request per pixel, with a skip
// flag and X, Y, Z float bit patterns. Results leave on rsp_chan: a vertex for
// every pixel that is not skipped, then a lower and an upper triangle for the
// quad that the pixel closes as its bottom-right corner, then the frame totals
// after the last pixel of the frame. last marks the final result of a request.
// csr_chan writes frame_width (index 0) and frame_height (index 1); either
// write restarts the frame. Write registers only while the block is idle.
//
// The first result of a request is offered once the request has passed the
// second stage register and been written into the result queue. Throughput:
// one request per cycle while each gives at most one result and the receiver
// takes results; a request with more results (up to four) holds back later
// requests, as the single result port drains a four-record queue. The line
// buffer RAM is read when a request is accepted, written back the next cycle.
// A stalled receiver fills the queue, and req_chan.ready drops once the queue
// and the pipeline register can take no more. Reset clears position, counts
// and neighbor marks; the line buffer needs no clearing pass, since row 0
// rewrites every entry before any later row reads it.
module depth_grid_mesh_triangulator (
   input  logic        clock,
   input  logic        reset,
   dgmt_req_if.sink    req_chan,
   dgmt_rsp_if.source  rsp_chan,
   dgmt_csr_if.sink    csr_chan
);
   import dgmt_pkg::*;

   // geometry, stored as last column and last row
   logic [COL_W-1:0]   width_last_ff;
   logic [ROW_W-1:0]   height_last_ff;

   // position and counts
   logic [COL_W-1:0]   col_count_ff;
   logic [ROW_W-1:0]   row_count_ff;
   logic [TOT_W-1:0]   vtx_count_ff;
   logic [FACE_W-1:0]  face_count_ff;
   logic [COL_W-1:0]   col_count_in;
   logic [ROW_W-1:0]   row_count_in;
   logic [TOT_W-1:0]   vtx_count_in;
   logic [FACE_W-1:0]  face_count_in;

   // neighbor registers
   logic [IDX_W-1:0]   above_left_index_ff;
   logic               above_left_valid_ff;
   logic [IDX_W-1:0]   left_index_ff;
   logic               left_valid_ff;

   // second stage, holds the pixel while the line buffer read returns
   logic               s1_valid_ff;
   logic               s1_px_valid_ff;
   logic [FLOAT_W-1:0] s1_x_ff;
   logic [FLOAT_W-1:0] s1_y_ff;
   logic [FLOAT_W-1:0] s1_z_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic               s1_row_nz_ff;
   logic               s1_col_nz_ff;
   logic               s1_col_end_ff;
   logic               s1_frame_end_ff;
   logic [IDX_W-1:0]   s1_cur_ff;
   logic [TOT_W-1:0]   s1_vtotal_ff;

   logic               csr_write;
   logic               cfg_width;
   logic               cfg_height;
   logic               restart;
   logic               req_accept;
   logic               px_valid;
   logic               col_end;
   logic               row_end;
   logic               frame_end;
   logic [TOT_W-1:0]   vtx_plus;

   logic [LINE_W-1:0]  line_rd;
   logic [IDX_W-1:0]   tr_index;
   logic               tr_valid;
   logic               quad_ok;
   logic               lower_tri;
   logic               upper_tri;
   logic [FACE_W-1:0]  face_sum;

   logic [Q_CNT_W-1:0] q_fill;
   logic [Q_CNT_W:0]   occupied;
   logic               push;
   result_rec_type     push_rec;

   // register writes
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign cfg_width      = csr_write && (csr_chan.index == CSR_FRAME_WIDTH);
   assign cfg_height     = csr_write && (csr_chan.index == CSR_FRAME_HEIGHT);
   assign restart        = cfg_width || cfg_height;

   // room for the record in stage 2 and for the one accepted now
   assign occupied       = {1'b0, q_fill} + (Q_CNT_W + 1)'(s1_valid_ff);
   assign req_chan.ready = (occupied < (Q_CNT_W + 1)'(Q_DEPTH));
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign px_valid  = !req_chan.skipped;
   assign col_end   = (col_count_ff == width_last_ff);
   assign row_end   = (row_count_ff == height_last_ff);
   assign frame_end = col_end && row_end;
   assign vtx_plus  = vtx_count_ff + TOT_W'(px_valid);

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      vtx_count_in = vtx_count_ff;
      if (restart) begin
         col_count_in = '0;
         row_count_in = '0;
         vtx_count_in = '0;
      end else if (req_accept) begin
         vtx_count_in = frame_end ? '0 : vtx_plus;
         if (col_end) begin
            col_count_in = '0;
            row_count_in = row_end ? '0 : row_count_ff + ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   // line buffer: valid mark and vertex index per column of the previous row
   dgmt_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_px_valid_ff, s1_cur_ff}),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (line_rd)
   );

   assign tr_valid  = line_rd[IDX_W];
   assign tr_index  = line_rd[IDX_W-1:0];
   assign quad_ok   = s1_px_valid_ff && s1_row_nz_ff && s1_col_nz_ff && above_left_valid_ff;
   assign lower_tri = quad_ok && left_valid_ff;
   assign upper_tri = quad_ok && tr_valid;
   assign face_sum  = face_count_ff + FACE_W'(lower_tri) + FACE_W'(upper_tri);

   always_comb begin
      face_count_in = face_count_ff;
      if (restart) begin
         face_count_in = '0;
      end else if (s1_valid_ff) begin
         face_count_in = s1_frame_end_ff ? '0 : face_sum;
      end
   end

   always_comb begin
      push_rec.flags.vertex = s1_px_valid_ff;
      push_rec.flags.lower  = lower_tri;
      push_rec.flags.upper  = upper_tri;
      push_rec.flags.totals = s1_frame_end_ff;
      push_rec.x            = s1_x_ff;
      push_rec.y            = s1_y_ff;
      push_rec.z            = s1_z_ff;
      push_rec.above_left   = above_left_index_ff;
      push_rec.left         = left_index_ff;
      push_rec.cur          = s1_cur_ff;
      push_rec.top_right    = tr_index;
      push_rec.vertex_total = s1_vtotal_ff;
      push_rec.face_total   = face_sum[TOT_W-1:0];
   end

   // a skipped pixel gives no record unless it ends the frame
   assign push = s1_valid_ff && (s1_px_valid_ff || s1_frame_end_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff       <= width_last(CFG_W'(WIDTH_RESET));
         height_last_ff      <= height_last(CFG_W'(HEIGHT_RESET));
         col_count_ff        <= '0;
         row_count_ff        <= '0;
         vtx_count_ff        <= '0;
         face_count_ff       <= '0;
         s1_valid_ff         <= 1'b0;
         above_left_index_ff <= '0;
         above_left_valid_ff <= 1'b0;
         left_index_ff       <= '0;
         left_valid_ff       <= 1'b0;
      end else begin
         if (cfg_width) width_last_ff <= width_last(csr_chan.data);
         if (cfg_height) height_last_ff <= height_last(csr_chan.data);
         col_count_ff  <= col_count_in;
         row_count_ff  <= row_count_in;
         vtx_count_ff  <= vtx_count_in;
         face_count_ff <= face_count_in;
         s1_valid_ff   <= req_accept;
         if (restart) begin
            above_left_valid_ff <= 1'b0;
            left_valid_ff       <= 1'b0;
         end else if (s1_valid_ff) begin
            above_left_index_ff <= tr_index;
            above_left_valid_ff <= s1_row_nz_ff && tr_valid && !s1_col_end_ff;
            left_index_ff       <= s1_cur_ff;
            left_valid_ff       <= s1_px_valid_ff && !s1_col_end_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_valid_ff  <= px_valid;
         s1_x_ff         <= clear_nan(req_chan.x_in);
         s1_y_ff         <= clear_nan(req_chan.y_in);
         s1_z_ff         <= clear_nan(req_chan.z_in ^ {1'b1, {(FLOAT_W - 1){1'b0}}});
         s1_col_ff       <= col_count_ff;
         s1_row_nz_ff    <= (row_count_ff != '0);
         s1_col_nz_ff    <= (col_count_ff != '0);
         s1_col_end_ff   <= col_end;
         s1_frame_end_ff <= frame_end;
         s1_cur_ff       <= vtx_count_ff[IDX_W-1:0];
         s1_vtotal_ff    <= vtx_plus;
      end
   end

   dgmt_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .fill     (q_fill),
      .rsp_chan (rsp_chan)
   );

   a_stage_follows : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not reach the line buffer stage");

   a_col_in_frame : assert property (@(posedge clock) disable iff (reset)
      col_count_ff <= width_last_ff)
      else $error("column count beyond frame width");

   a_row_in_frame : assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= height_last_ff)
      else $error("row count beyond frame height");

   a_totals_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == KIND_TOTALS) |-> rsp_chan.last)
      else $error("frame totals not marked last");
endmodule
